FILE: rtl/chme_pkg.sv
// Package for the chained hash map engine: operation codes, status codes
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package chme_pkg;

  // Operation codes carried on the kind port.
  localparam logic [2:0] KIND_PUT    = 3'd0;
  localparam logic [2:0] KIND_GET    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_START  = 3'd4;
  localparam logic [2:0] KIND_NEXT   = 3'd5;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_ENDED     = 2'd2;
  localparam logic [1:0] STATUS_DISTURBED = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_HASH = 13'b0000000000010,
    S_HEAD = 13'b0000000000100,
    S_LOOK = 13'b0000000001000,
    S_WRD  = 13'b0000000010000,
    S_WCMP = 13'b0000000100000,
    S_HIT  = 13'b0000001000000,
    S_RM2  = 13'b0000010000000,
    S_MISS = 13'b0000100000000,
    S_ALC1 = 13'b0001000000000,
    S_ALC2 = 13'b0010000000000,
    S_NEXT = 13'b0100000000000,
    S_RESP = 13'b1000000000000
  } state_t;

endpackage

FILE: rtl/chme_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module chme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/chained_hash_map_engine.sv
// Top level of the chained hash map engine: sequencer, registers and the
// slot and bucket memories. Depends on chme_pkg and chme_ram.
`timescale 1ns / 1ps

// How to use this block:
// A request is given on kind, key and value and is taken at the rising edge
// where start is high and busy is low. Busy stays high until the result has
// been shown. Each request gives exactly one result, shown for one cycle with
// done high; the receiver cannot stall it and must take it in that cycle.
// Clear, start iteration and unused kinds go straight to the result; next
// first reads the entry in S_NEXT, unless the iteration has ended or was
// disturbed. Put, get and remove walk the bucket chain through the slot
// memories, with a memory read step and a compare step per chain entry
// visited; an insert adds the allocation states S_ALC1 and S_ALC2. With a
// power-of-two bucket count the bucket is the key's low bits; otherwise a
// shared restoring subtractor forms key mod BUCKETS bit by bit.
// One item is in flight at a time.
// Reset (synchronous) empties the table, all buckets and the order list at
// once; no memory sweep is needed, so the block is ready right after reset.

module chained_hash_map_engine #(
  parameter int CAPACITY   = 256,
  parameter int BUCKETS    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          kind,
  input  logic [KEY_BITS-1:0]                 key,
  input  logic [VALUE_BITS-1:0]               value,
  output logic                                done,
  output logic                                found,
  output logic [VALUE_BITS-1:0]               value_out,
  output logic [KEY_BITS-1:0]                 key_out,
  output logic [1:0]                          status,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
  output logic [$clog2(CAPACITY+1)-1:0]       left_to_visit
);

  import chme_pkg::*;

  localparam int  PW   = $clog2(CAPACITY + 1);
  localparam int  SW   = $clog2(CAPACITY);
  localparam int  BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  CW   = $clog2(KEY_BITS + 1);
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [PW-1:0] NONE = PW'(CAPACITY);

  state_t state;

  // Request registers.
  logic [2:0]            op;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // Bucket computation.
  logic [BW-1:0]         bkt;
  logic [KEY_BITS-1:0]   hshift;
  logic [CW-1:0]         hcnt;
  logic [KEY_BITS+BW-1:0] keyx;
  logic [BW:0]           rem_t;
  logic [BW-1:0]         bkt_low;
  logic [BW-1:0]         bkt_step;

  // Walk and table registers.
  logic [PW-1:0]         slot;
  logic [PW-1:0]         prev;
  logic [PW-1:0]         link_s;
  logic [PW-1:0]         head_sv;
  logic                  recycled;
  logic [PW-1:0]         list_head;
  logic [PW-1:0]         list_tail;
  logic [PW-1:0]         free_head;
  logic [PW-1:0]         fresh;
  logic [PW-1:0]         stored;
  logic [31:0]           change;
  logic [PW-1:0]         cursor;
  logic [31:0]           cur_exp;
  logic [PW-1:0]         visited;
  logic [BUCKETS-1:0]    hvalid;

  // Result registers.
  logic                  found_r;
  logic [VALUE_BITS-1:0] vout_r;
  logic [KEY_BITS-1:0]   kout_r;
  logic [1:0]            status_r;

  // Memory ports.
  logic                  key_we, val_we, link_we, head_we, onext_we, oprev_we;
  logic [SW-1:0]         slot_raddr, link_raddr;
  logic [SW-1:0]         link_waddr, onext_waddr, oprev_waddr;
  logic [PW-1:0]         link_wdata, head_wdata, onext_wdata, oprev_wdata;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [PW-1:0]         link_q, head_q, onext_q, oprev_q;

  logic                  is_rm_hit;
  logic                  disturbed;

  assign is_rm_hit = (state == S_HIT) && (op == KIND_REMOVE);

  // Bucket of the key: low bits, or one restoring subtract step per cycle.
  assign keyx     = {{BW{1'b0}}, key_r};
  assign bkt_low  = (BUCKETS == 1) ? '0 : keyx[BW-1:0];
  assign rem_t    = {bkt, hshift[KEY_BITS-1]};
  assign bkt_step = (rem_t >= (BW+1)'(BUCKETS)) ? BW'(rem_t - (BW+1)'(BUCKETS))
                                                : rem_t[BW-1:0];

  // Reads: cursor when idle, else slot; link: slot, or free_head in S_MISS.
  assign slot_raddr = (state == S_IDLE) ? cursor[SW-1:0] : slot[SW-1:0];
  assign link_raddr = (state == S_MISS) ? free_head[SW-1:0] : slot[SW-1:0];

  // Write port steering.
  always_comb begin
    key_we      = (state == S_ALC1);
    val_we      = (state == S_ALC1) || ((state == S_HIT) && (op == KIND_PUT));
    link_we     = (is_rm_hit && (prev != NONE)) || (state == S_RM2) ||
                  (state == S_ALC1);
    link_waddr  = slot[SW-1:0];
    link_wdata  = free_head;
    head_we     = (is_rm_hit && (prev == NONE)) || (state == S_ALC1);
    head_wdata  = slot;
    onext_we    = (is_rm_hit && (oprev_q != NONE)) || (state == S_ALC1) ||
                  ((state == S_ALC2) && (list_tail != NONE));
    onext_waddr = slot[SW-1:0];
    onext_wdata = NONE;
    oprev_we    = (is_rm_hit && (onext_q != NONE)) || (state == S_ALC1);
    oprev_waddr = slot[SW-1:0];
    oprev_wdata = list_tail;
    if (state == S_HIT) begin
      link_waddr  = prev[SW-1:0];
      link_wdata  = link_s;
      head_wdata  = link_s;
      onext_waddr = oprev_q[SW-1:0];
      onext_wdata = onext_q;
      oprev_waddr = onext_q[SW-1:0];
      oprev_wdata = oprev_q;
    end else if (state == S_ALC1) begin
      link_wdata = head_sv;
    end else if (state == S_ALC2) begin
      onext_waddr = list_tail[SW-1:0];
      onext_wdata = slot;
    end
  end

  // Slot and bucket memories.
  chme_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_mem (
    .clk(clk), .we(key_we), .waddr(slot[SW-1:0]), .wdata(key_r),
    .raddr(slot_raddr), .rdata(key_q)
  );
  chme_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_mem (
    .clk(clk), .we(val_we), .waddr(slot[SW-1:0]), .wdata(val_r),
    .raddr(slot_raddr), .rdata(val_q)
  );
  chme_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_mem (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_q)
  );
  chme_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_onext_mem (
    .clk(clk), .we(onext_we), .waddr(onext_waddr), .wdata(onext_wdata),
    .raddr(slot_raddr), .rdata(onext_q)
  );
  chme_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_oprev_mem (
    .clk(clk), .we(oprev_we), .waddr(oprev_waddr), .wdata(oprev_wdata),
    .raddr(slot_raddr), .rdata(oprev_q)
  );
  chme_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_mem (
    .clk(clk), .we(head_we), .waddr(bkt), .wdata(head_wdata),
    .raddr(bkt), .rdata(head_q)
  );

  // Sequencer and table registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NONE;
      list_tail <= NONE;
      free_head <= NONE;
      fresh     <= '0;
      stored    <= '0;
      change    <= '0;
      cursor    <= NONE;
      cur_exp   <= '0;
      visited   <= '0;
      hvalid    <= '0;
      found_r   <= 1'b0;
      status_r  <= STATUS_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op       <= kind;
            key_r    <= key;
            val_r    <= value;
            hshift   <= key;
            hcnt     <= CW'(KEY_BITS);
            bkt      <= '0;
            found_r  <= 1'b0;
            vout_r   <= '0;
            kout_r   <= '0;
            status_r <= STATUS_OK;
            state    <= S_RESP;
            case (kind) inside
              KIND_PUT, KIND_GET, KIND_REMOVE: begin
                state <= S_HASH;
              end
              KIND_CLEAR: begin
                change    <= change + 32'(stored);
                stored    <= '0;
                free_head <= NONE;
                fresh     <= '0;
                list_head <= NONE;
                list_tail <= NONE;
                hvalid    <= '0;
              end
              KIND_START: begin
                cursor  <= list_head;
                cur_exp <= change;
                visited <= '0;
              end
              KIND_NEXT: begin
                if (cursor == NONE) begin
                  status_r <= STATUS_ENDED;
                end else if (cur_exp != change) begin
                  status_r <= STATUS_DISTURBED;
                end else begin
                  state <= S_NEXT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_HASH: begin
          if (POW2) begin
            bkt   <= bkt_low;
            state <= S_HEAD;
          end else if (hcnt == '0) begin
            state <= S_HEAD;
          end else begin
            bkt    <= bkt_step;
            hshift <= hshift << 1;
            hcnt   <= hcnt - 1'b1;
          end
        end
        S_HEAD: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          slot    <= hvalid[bkt] ? head_q : NONE;
          head_sv <= hvalid[bkt] ? head_q : NONE;
          prev    <= NONE;
          state   <= S_WRD;
        end
        S_WRD: begin
          state <= (slot == NONE) ? S_MISS : S_WCMP;
        end
        S_WCMP: begin
          if (key_q == key_r) begin
            found_r <= 1'b1;
            vout_r  <= val_q;
            link_s  <= link_q;
            state   <= S_HIT;
          end else begin
            prev  <= slot;
            slot  <= link_q;
            state <= S_WRD;
          end
        end
        S_HIT: begin
          if (op == KIND_REMOVE) begin
            // Unlink from the order list; the chain unlink is a memory write.
            if (oprev_q == NONE) begin
              list_head <= onext_q;
            end
            if (onext_q == NONE) begin
              list_tail <= oprev_q;
            end
            state <= S_RM2;
          end else begin
            state <= S_RESP;
          end
        end
        S_RM2: begin
          free_head <= slot;
          if (stored != '0) begin
            stored <= stored - 1'b1;
          end
          change <= change + 32'd1;
          state  <= S_RESP;
        end
        S_MISS: begin
          state <= S_RESP;
          if (op == KIND_PUT) begin
            if (stored == NONE) begin
              status_r <= STATUS_FULL;
            end else if (free_head != NONE) begin
              slot     <= free_head;
              recycled <= 1'b1;
              state    <= S_ALC1;
            end else begin
              slot     <= fresh;
              fresh    <= fresh + 1'b1;
              recycled <= 1'b0;
              state    <= S_ALC1;
            end
          end
        end
        S_ALC1: begin
          if (recycled) begin
            free_head <= link_q;
          end
          hvalid[bkt] <= 1'b1;
          stored      <= stored + 1'b1;
          change      <= change + 32'd1;
          state       <= S_ALC2;
        end
        S_ALC2: begin
          if (list_tail == NONE) begin
            list_head <= slot;
          end
          list_tail <= slot;
          state     <= S_RESP;
        end
        S_NEXT: begin
          found_r <= 1'b1;
          kout_r  <= key_q;
          vout_r  <= val_q;
          visited <= visited + 1'b1;
          cursor  <= onext_q;
          state   <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports.
  assign disturbed     = (cur_exp != change);
  assign busy          = (state != S_IDLE);
  assign done          = (state == S_RESP);
  assign found         = found_r;
  assign value_out     = vout_r;
  assign key_out       = kout_r;
  assign status        = status_r;
  assign entry_count   = stored;
  assign left_to_visit = (disturbed || (visited >= stored)) ? '0 : stored - visited;

endmodule
